### rtl/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types, field widths, status codes and HCS constants for the PHY
// header pack/check block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpc_pkg;

    localparam int SEED_W   = 7;
    localparam int MCS_W    = 5;
    localparam int LEN_W    = 18;
    localparam int TRN_W    = 5;
    localparam int RSSI_W   = 4;
    localparam int HDR_W    = 64;
    localparam int HCS_W    = 16;
    localparam int HCS_SPAN = 48;
    localparam int STAT_W   = 2;

    localparam logic [HCS_W-1:0] HCS_POLY = 16'h1021;
    localparam logic [HCS_W-1:0] HCS_INIT = 16'hFFFF;
    localparam logic [MCS_W-1:0] MAX_MCS_RESET = 5'd12;

    // Stream payload widths (fields packed LSB first, padded to bytes).
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 112;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_MCS_BAD  = 2'd1,
        ST_LEN_ZERO = 2'd2,
        ST_HCS_BAD  = 2'd3
    } t_status;

    typedef enum logic {
        CMD_FORMAT = 1'b0,
        CMD_PARSE  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [SEED_W-1:0] seed;
        logic [MCS_W-1:0]  mcs;
        logic [LEN_W-1:0]  length;
        logic              pkt_type;
        logic [TRN_W-1:0]  trn;
        logic              beam_req;
        logic [RSSI_W-1:0] rssi;
        logic [HDR_W-1:0]  header;
    } t_req;

    typedef struct packed {
        logic [HDR_W-1:0]  header;
        logic [SEED_W-1:0] seed;
        logic [MCS_W-1:0]  mcs;
        logic [LEN_W-1:0]  length;
        logic              pkt_type;
        logic [TRN_W-1:0]  trn;
        logic              beam_req;
        logic [RSSI_W-1:0] rssi;
        t_status           status;
    } t_rsp;

    // Bit-serial CRC, elaboration use only (builds the XOR matrix below).
    function automatic logic [HCS_W-1:0] hcs_serial(input logic [HCS_SPAN-1:0] data,
                                                    input logic [HCS_W-1:0] init);
        logic [HCS_W-1:0] crc;
        logic             fb;
        crc = init;
        for (int i = 0; i < HCS_SPAN; i++) begin
            fb  = crc[HCS_W-1] ^ data[i];
            crc = {crc[HCS_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ HCS_POLY;
            end
        end
        return crc;
    endfunction

    // Column i: contribution of data bit i to the final register (init 0).
    function automatic logic [HCS_SPAN*HCS_W-1:0] hcs_cols();
        logic [HCS_SPAN*HCS_W-1:0] cols;
        logic [HCS_SPAN-1:0]       unit;
        cols = '0;
        for (int i = 0; i < HCS_SPAN; i++) begin
            unit = '0;
            unit[i] = 1'b1;
            cols[i*HCS_W +: HCS_W] = hcs_serial(unit, '0);
        end
        return cols;
    endfunction

    localparam logic [HCS_SPAN*HCS_W-1:0] HCS_COLS = hcs_cols();
    localparam logic [HCS_W-1:0] HCS_INIT_TERM = hcs_serial('0, HCS_INIT);

endpackage

`default_nettype wire

### rtl/hpc_crc.sv
// ----------------------------------------------------------------------------
// hpc_crc
// Parallel CRC-16 (0x1021) over 48 header bits, one flat XOR matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module hpc_crc
    import hpc_pkg::*;
(
    input  wire logic [HCS_SPAN-1:0] i_data,
    output logic      [HCS_W-1:0]    o_hcs
);

    always_comb begin
        o_hcs = HCS_INIT_TERM;
        for (int j = 0; j < HCS_W; j++) begin
            for (int i = 0; i < HCS_SPAN; i++) begin
                o_hcs[j] = o_hcs[j] ^ (i_data[i] & HCS_COLS[i*HCS_W + j]);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/hpc_core.sv
// ----------------------------------------------------------------------------
// hpc_core
// Header pack (format) and unpack/check (parse) for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module hpc_core
    import hpc_pkg::*;
(
    input  wire t_req             i_req,
    input  wire logic [MCS_W-1:0] i_max_mcs,
    output t_rsp                  o_rsp
);

    logic [HCS_SPAN-1:0] fmt_body;
    logic [HCS_SPAN-1:0] crc_data;
    logic [HCS_W-1:0]    hcs;
    logic [HDR_W-1:0]    h;

    // Fixed bits (additional, aggregation, turnaround, reserved) stay zero.
    assign fmt_body = {4'b0, 1'b0, i_req.rssi, i_req.beam_req, 1'b0, i_req.trn,
                       i_req.pkt_type, 1'b0, i_req.length, i_req.mcs, i_req.seed};

    assign h        = i_req.header;
    assign crc_data = (i_req.cmd == CMD_PARSE) ? h[HCS_SPAN-1:0] : fmt_body;

    hpc_crc u_crc (
        .i_data (crc_data),
        .o_hcs  (hcs)
    );

    always_comb begin
        o_rsp = '0;
        if (i_req.cmd == CMD_FORMAT) begin
            o_rsp.header = {hcs, fmt_body};
            o_rsp.status = ST_OK;
        end else begin
            o_rsp.seed     = h[6:0];
            o_rsp.mcs      = h[11:7];
            o_rsp.length   = h[29:12];
            o_rsp.pkt_type = h[31];
            o_rsp.trn      = h[36:32];
            o_rsp.beam_req = h[38];
            o_rsp.rssi     = h[42:39];
            priority if (h[11:7] > i_max_mcs) begin
                o_rsp.status = ST_MCS_BAD;
            end else if (h[29:12] == '0) begin
                o_rsp.status = ST_LEN_ZERO;
            end else if (h[63:48] != hcs) begin
                o_rsp.status = ST_HCS_BAD;
            end else begin
                o_rsp.status = ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/phy_header_pack_check_top.sv
// ----------------------------------------------------------------------------
// phy_header_pack_check_top
// PHY header formatter / parser with CRC-16 HCS and a configurable MCS limit.
// Pipeline: input reg, then result reg, from input request to result.
// Throughput: 1 request per cycle unless the output stalls; set by the
//   single-pass CRC/pack logic between the input and result registers.
// Reset: i_rst_n synchronous active low; clears both stage valids and
//   loads max_mcs with 12.
// ----------------------------------------------------------------------------
`default_nettype none

module phy_header_pack_check_top
    import hpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config: max_mcs
    input  wire logic                 i_cfg_we,
    input  wire logic [MCS_W-1:0]     i_cfg_wdata,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata LSB up: seed_in[6:0], mcs_in[11:7], length_in[29:12], type_in[30],
    //   trn_in[35:31], beam_req_in[36], rssi_in[40:37], header_in[104:41], pad
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: cmd (0 format, 1 parse)
    input  wire logic                 s_axis_tuser,
    // output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata LSB up: header_out[63:0], seed_out[70:64], mcs_out[75:71],
    //   length_out[93:76], type_out[94], trn_out[99:95], beam_req_out[100],
    //   rssi_out[104:101], status[106:105], pad
    output logic      [M_TDATA_W-1:0] m_axis_tdata
);

    // ---- config register ----
    logic [MCS_W-1:0] r_max_mcs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mcs <= MAX_MCS_RESET;
        end else if (i_cfg_we) begin
            r_max_mcs <= i_cfg_wdata;
        end
    end

    // ---- handshake: each stage advances when the one after it has room ----
    logic r_in_valid;
    logic r_out_valid;
    logic out_room;
    logic in_room;

    assign out_room      = !r_out_valid || m_axis_tready;
    assign in_room       = !r_in_valid || out_room;
    assign s_axis_tready = in_room;

    // ---- input register: unpack the request ----
    t_req r_req;
    t_req n_req;

    always_comb begin
        n_req.cmd      = t_cmd'(s_axis_tuser);
        n_req.seed     = s_axis_tdata[6:0];
        n_req.mcs      = s_axis_tdata[11:7];
        n_req.length   = s_axis_tdata[29:12];
        n_req.pkt_type = s_axis_tdata[30];
        n_req.trn      = s_axis_tdata[35:31];
        n_req.beam_req = s_axis_tdata[36];
        n_req.rssi     = s_axis_tdata[40:37];
        n_req.header   = s_axis_tdata[104:41];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_room) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_room && s_axis_tvalid) begin
            r_req <= n_req;
        end
    end

    // ---- pack / parse in one pass ----
    t_rsp n_rsp;
    t_rsp r_rsp;

    hpc_core u_core (
        .i_req     (r_req),
        .i_max_mcs (r_max_mcs),
        .o_rsp     (n_rsp)
    );

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_room) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_room && r_in_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_rsp.status, r_rsp.rssi, r_rsp.beam_req, r_rsp.trn,
                            r_rsp.pkt_type, r_rsp.length, r_rsp.mcs, r_rsp.seed,
                            r_rsp.header};

    // ---- assertions ----
    // The source is back-pressured only while both stages are full.
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("tready low without both stages full");

    // A result only appears after a request sat in the input stage.
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_in_valid))
        else $error("result without a request");

    // Nonzero status only comes from parse, whose header field is zero.
    a_parse_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.status != ST_OK) |-> (r_rsp.header == '0))
        else $error("error status with a formatted header");

    // MCS limit reloads to its default out of reset.
    a_rst_cfg: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_max_mcs == MAX_MCS_RESET))
        else $error("max_mcs not reset");

endmodule

`default_nettype wire
